/* sv/circle_segment_wall_pushout_unit_macros.svh */
// Assertion macros for the circle/segment wall push-out unit.
// Included by the top level; expects clk and rst_n in scope.
`ifndef CIRCLE_SEGMENT_WALL_PUSHOUT_UNIT_MACROS_SVH
`define CIRCLE_SEGMENT_WALL_PUSHOUT_UNIT_MACROS_SVH

// same-cycle implication
`define CSWP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CSWP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/cswp_pkg.sv */
// Shared constants, types and fixed-point helpers of the wall push-out unit.
// No dependencies.
package cswp_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int MAX_WALLS_DEF = 8;
    localparam int HALF_WALL     = (3 << FRAC_BITS) / 10;
    localparam int DIV_STEPS     = FRAC_BITS + 1;
    localparam int SQRT_STEPS    = 32;

    localparam int DIN_W  = 264;
    localparam int DOUT_W = 136;

    localparam logic CFG_WALL_COUNT  = 1'b0;
    localparam logic CFG_BODY_RADIUS = 1'b1;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_RESOLVE = 1'b1;

    typedef struct packed {
        logic start;
        logic is_sqrt;
    } iter_cmd_t;

    // product / 2^F, rounded toward zero
    function automatic logic signed [67:0] qtrunc(input logic signed [67:0] p);
        logic signed [67:0] m;
        m = p[67] ? -p : p;
        m = m >>> FRAC_BITS;
        return p[67] ? -m : m;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        if (v[67:31] != {37{v[67]}})
            return v[67] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        return v[31:0];
    endfunction

endpackage

/* sv/circle_segment_wall_pushout_unit.sv */
// Circle versus wall segment push-out. Write transfers are taken while idle.
// Resolve: per checked wall, the shared iterative unit runs a 17-step divide
// unless the projection is trivial, a 32-step square root if the wall is near and
// two 17-step divides if it is hit; the output can stall.
// One transfer at a time; the result register lets the next transfer in.
// rst_n (async) clears control and wall count and sets radius to 1.0; wall store is undefined until written.
`include "circle_segment_wall_pushout_unit_macros.svh"

module circle_segment_wall_pushout_unit
    import cswp_pkg::*;
#(
    parameter int MAX_WALLS = MAX_WALLS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    // config write port
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [30:0]       cfg_data,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    // wall_slot, start_x, start_z, end_x, end_z, pos_x, pos_z, vel_x, vel_z, pad
    input  logic [DIN_W-1:0]  s_tdata,
    // operation
    input  logic              s_tuser,
    // output stream
    output logic              m_tvalid,
    input  logic              m_tready,
    // new_pos_x, new_pos_z, new_vel_x, new_vel_z, walls_hit, pad
    output logic [DOUT_W-1:0] m_tdata
);

    localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;

    // sequencer states
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_RD   = 5'd1;
    localparam logic [4:0] S_LOAD = 5'd2;
    localparam logic [4:0] S_LA   = 5'd3;
    localparam logic [4:0] S_LB   = 5'd4;
    localparam logic [4:0] S_DA   = 5'd5;
    localparam logic [4:0] S_DB   = 5'd6;
    localparam logic [4:0] S_PROJ = 5'd7;
    localparam logic [4:0] S_WT   = 5'd8;
    localparam logic [4:0] S_CX   = 5'd9;
    localparam logic [4:0] S_CZ   = 5'd10;
    localparam logic [4:0] S_CHK  = 5'd11;
    localparam logic [4:0] S_SX   = 5'd12;
    localparam logic [4:0] S_SZ   = 5'd13;
    localparam logic [4:0] S_SQ   = 5'd14;
    localparam logic [4:0] S_WS   = 5'd15;
    localparam logic [4:0] S_CHD  = 5'd16;
    localparam logic [4:0] S_WX   = 5'd17;
    localparam logic [4:0] S_WZ   = 5'd18;
    localparam logic [4:0] S_IA   = 5'd19;
    localparam logic [4:0] S_IB   = 5'd20;
    localparam logic [4:0] S_PX   = 5'd21;
    localparam logic [4:0] S_PZ   = 5'd22;
    localparam logic [4:0] S_VX   = 5'd23;
    localparam logic [4:0] S_VZ   = 5'd24;
    localparam logic [4:0] S_NEXT = 5'd25;
    localparam logic [4:0] S_OUT  = 5'd26;

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    // shift right by s, rounding toward zero
    function automatic logic signed [30:0] scl(input logic signed [32:0] v,
                                               input logic [1:0] s);
        logic [32:0] m;
        m = mag33(v) >> s;
        return v[32] ? -$signed(31'(m)) : $signed(31'(m));
    endfunction

    // config
    logic [3:0]  wall_count_reg;
    logic [30:0] body_radius_reg;
    logic [31:0] ko;
    logic [3:0]  nwalls;

    // control
    logic [4:0]  state_reg, state_next;
    logic        m_tvalid_reg;
    logic        in_xfer, out_load, wr_en;
    logic        in_wait;

    // wall store
    logic [127:0]   wall_mem [MAX_WALLS];
    logic [127:0]   mem_q;
    logic [AW-1:0]  rd_addr;

    // datapath
    logic [3:0]         idx_reg, hits_reg;
    logic signed [31:0] px_reg, pz_reg, vx_reg, vz_reg;
    logic signed [31:0] wsx_reg, wsz_reg;
    logic signed [32:0] abx_reg, abz_reg;
    logic signed [30:0] sbx_reg, sbz_reg, spx_reg, spz_reg;
    logic signed [65:0] acc_reg;
    logic [61:0]        len2_reg;
    logic [16:0]        t_reg;
    logic signed [34:0] dx_reg, dz_reg;
    logic [32:0]        d_reg;
    logic signed [17:0] nx_reg, nz_reg;
    logic signed [33:0] into_reg;
    logic [131:0]       out_reg;

    // wall decode at load
    logic signed [31:0] w_sx, w_sz, w_ex, w_ez;
    logic signed [32:0] ab_x, ab_z, ap_x, ap_z;
    logic [32:0]        m01, m23, mmax;
    logic [1:0]         sh;

    // shared multiplier
    logic signed [33:0] op_a, op_b;
    logic signed [67:0] prod;
    logic signed [33:0] push;

    // iterative unit
    iter_cmd_t   icmd;
    logic [63:0] inum, iden, ires;
    logic        idone;
    logic        proj_trivial, chk_miss, chd_ok;
    logic [34:0] adx, adz;
    logic signed [17:0] q18;

    assign ko     = {1'b0, body_radius_reg} + 32'(HALF_WALL);
    assign nwalls = (int'(wall_count_reg) > MAX_WALLS) ? 4'(MAX_WALLS) : wall_count_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign wr_en    = in_xfer && (s_tuser == OP_WRITE) && (int'(s_tdata[2:0]) < MAX_WALLS);
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, out_reg};
    assign in_wait  = (state_reg == S_WT) || (state_reg == S_WS) ||
                      (state_reg == S_WX) || (state_reg == S_WZ);

    // ---- wall store: one write port, one registered read port ----
    assign rd_addr = AW'(idx_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            wall_mem[AW'(s_tdata[2:0])] <= s_tdata[130:3];
        mem_q <= wall_mem[rd_addr];
    end

    assign w_sx = $signed(mem_q[31:0]);
    assign w_sz = $signed(mem_q[63:32]);
    assign w_ex = $signed(mem_q[95:64]);
    assign w_ez = $signed(mem_q[127:96]);
    assign ab_x = 33'(w_ex) - 33'(w_sx);
    assign ab_z = 33'(w_ez) - 33'(w_sz);
    assign ap_x = 33'(px_reg) - 33'(w_sx);
    assign ap_z = 33'(pz_reg) - 33'(w_sz);
    assign m01  = (mag33(ab_x) > mag33(ab_z)) ? mag33(ab_x) : mag33(ab_z);
    assign m23  = (mag33(ap_x) > mag33(ap_z)) ? mag33(ap_x) : mag33(ap_z);
    assign mmax = (m01 > m23) ? m01 : m23;
    // common scale so every component drops below 2^30
    assign sh   = mmax[32] ? 2'd3 : mmax[31] ? 2'd2 : mmax[30] ? 2'd1 : 2'd0;

    // ---- multiplier operand select ----
    assign push = $signed({2'b0, ko}) - $signed({1'b0, d_reg});

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            S_LA:    begin op_a = 34'(sbx_reg); op_b = 34'(sbx_reg); end
            S_LB:    begin op_a = 34'(sbz_reg); op_b = 34'(sbz_reg); end
            S_DA:    begin op_a = 34'(spx_reg); op_b = 34'(sbx_reg); end
            S_DB:    begin op_a = 34'(spz_reg); op_b = 34'(sbz_reg); end
            S_CX:    begin op_a = 34'(abx_reg); op_b = $signed({17'b0, t_reg}); end
            S_CZ:    begin op_a = 34'(abz_reg); op_b = $signed({17'b0, t_reg}); end
            S_SX:    begin op_a = 34'(dx_reg);  op_b = 34'(dx_reg); end
            S_SZ:    begin op_a = 34'(dz_reg);  op_b = 34'(dz_reg); end
            S_IA:    begin op_a = 34'(vx_reg);  op_b = 34'(nx_reg); end
            S_IB:    begin op_a = 34'(vz_reg);  op_b = 34'(nz_reg); end
            S_PX:    begin op_a = 34'(nx_reg);  op_b = push; end
            S_PZ:    begin op_a = 34'(nz_reg);  op_b = push; end
            S_VX:    begin op_a = 34'(nx_reg);  op_b = into_reg; end
            S_VZ:    begin op_a = 34'(nz_reg);  op_b = into_reg; end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    assign prod = op_a * op_b;

    // ---- decisions ----
    assign proj_trivial = (len2_reg == '0) || (acc_reg <= 0) ||
                          (acc_reg >= $signed({4'b0, len2_reg}));
    assign adx      = dx_reg[34] ? 35'(-dx_reg) : 35'(dx_reg);
    assign adz      = dz_reg[34] ? 35'(-dz_reg) : 35'(dz_reg);
    assign chk_miss = (adx >= {3'b0, ko}) || (adz >= {3'b0, ko});
    assign chd_ok   = (d_reg != '0) && (d_reg < {1'b0, ko});
    assign q18      = $signed({1'b0, ires[16:0]});

    // ---- iterative unit command ----
    always_comb
    begin
        icmd.start   = 1'b0;
        icmd.is_sqrt = 1'b0;
        inum         = '0;
        iden         = '0;
        case (state_reg)
            S_PROJ:
            begin
                icmd.start = !proj_trivial;
                inum       = acc_reg[63:0];
                iden       = {2'b0, len2_reg};
            end
            S_SQ:
            begin
                icmd.start   = 1'b1;
                icmd.is_sqrt = 1'b1;
                inum         = acc_reg[63:0];
            end
            S_CHD:
            begin
                icmd.start = chd_ok;
                inum       = {29'b0, adx};
                iden       = {31'b0, d_reg};
            end
            S_WX:
            begin
                icmd.start = idone;
                inum       = {29'b0, adz};
                iden       = {31'b0, d_reg};
            end
            default:
            begin
                icmd.start = 1'b0;
            end
        endcase
    end

    cswp_iter_unit u_iter (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (icmd),
        .num    (inum),
        .den    (iden),
        .done   (idone),
        .result (ires)
    );

    // ---- sequencer ----
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_xfer && s_tuser == OP_RESOLVE)
                    state_next = (nwalls == 4'd0) ? S_OUT : S_RD;
            S_RD:   state_next = S_LOAD;
            S_LOAD: state_next = S_LA;
            S_LA:   state_next = S_LB;
            S_LB:   state_next = S_DA;
            S_DA:   state_next = S_DB;
            S_DB:   state_next = S_PROJ;
            S_PROJ: state_next = proj_trivial ? S_CX : S_WT;
            S_WT:   if (idone) state_next = S_CX;
            S_CX:   state_next = S_CZ;
            S_CZ:   state_next = S_CHK;
            S_CHK:  state_next = chk_miss ? S_NEXT : S_SX;
            S_SX:   state_next = S_SZ;
            S_SZ:   state_next = S_SQ;
            S_SQ:   state_next = S_WS;
            S_WS:   if (idone) state_next = S_CHD;
            S_CHD:  state_next = chd_ok ? S_WX : S_NEXT;
            S_WX:   if (idone) state_next = S_WZ;
            S_WZ:   if (idone) state_next = S_IA;
            S_IA:   state_next = S_IB;
            S_IB:   state_next = S_PX;
            S_PX:   state_next = S_PZ;
            S_PZ:   state_next = S_VX;
            S_VX:   state_next = S_VZ;
            S_VZ:   state_next = S_NEXT;
            S_NEXT:
                state_next = (({1'b0, idx_reg} + 5'd1) >= {1'b0, nwalls}) ? S_OUT : S_RD;
            S_OUT:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            m_tvalid_reg    <= 1'b0;
            wall_count_reg  <= '0;
            body_radius_reg <= 31'd65536;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            if (cfg_we)
            begin
                if (cfg_index == CFG_WALL_COUNT)
                    wall_count_reg <= cfg_data[3:0];
                else if (cfg_index == CFG_BODY_RADIUS)
                    body_radius_reg <= cfg_data;
            end
        end
    end

    // ---- datapath ----
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (in_xfer && s_tuser == OP_RESOLVE)
                begin
                    px_reg   <= $signed(s_tdata[162:131]);
                    pz_reg   <= $signed(s_tdata[194:163]);
                    vx_reg   <= $signed(s_tdata[226:195]);
                    vz_reg   <= $signed(s_tdata[258:227]);
                    hits_reg <= '0;
                    idx_reg  <= '0;
                end
            S_LOAD:
            begin
                wsx_reg <= w_sx;
                wsz_reg <= w_sz;
                abx_reg <= ab_x;
                abz_reg <= ab_z;
                sbx_reg <= scl(ab_x, sh);
                sbz_reg <= scl(ab_z, sh);
                spx_reg <= scl(ap_x, sh);
                spz_reg <= scl(ap_z, sh);
            end
            S_LA:   acc_reg  <= 66'(prod);
            S_LB:   len2_reg <= 62'(68'(acc_reg) + prod);
            S_DA:   acc_reg  <= 66'(prod);
            S_DB:   acc_reg  <= 66'(68'(acc_reg) + prod);   // dot product
            S_PROJ:
                t_reg <= ((len2_reg == '0) || (acc_reg <= 0)) ? 17'd0 : 17'(1 << FRAC_BITS);
            S_WT:   if (idone) t_reg <= ires[16:0];
            S_CX:   dx_reg <= 35'(68'(px_reg) - 68'(wsx_reg) - qtrunc(prod));
            S_CZ:   dz_reg <= 35'(68'(pz_reg) - 68'(wsz_reg) - qtrunc(prod));
            S_SX:   acc_reg <= 66'(prod);
            S_SZ:   acc_reg <= 66'(68'(acc_reg) + prod);    // squared distance
            S_WS:   if (idone) d_reg <= ires[32:0];
            S_WX:   if (idone) nx_reg <= dx_reg[34] ? -q18 : q18;
            S_WZ:   if (idone) nz_reg <= dz_reg[34] ? -q18 : q18;
            S_IA:   acc_reg  <= 66'(prod);
            S_IB:   into_reg <= 34'(qtrunc(68'(acc_reg) + prod));
            S_PX:   px_reg <= sat32(68'(px_reg) + qtrunc(prod));
            S_PZ:   pz_reg <= sat32(68'(pz_reg) + qtrunc(prod));
            S_VX:   if (into_reg[33]) vx_reg <= sat32(68'(vx_reg) - qtrunc(prod));
            S_VZ:
            begin
                if (into_reg[33])
                    vz_reg <= sat32(68'(vz_reg) - qtrunc(prod));
                if (hits_reg != 4'd15)
                    hits_reg <= hits_reg + 4'd1;
            end
            S_NEXT: idx_reg <= idx_reg + 4'd1;
            S_OUT:
                if (out_load)
                    out_reg <= {hits_reg, vz_reg, vx_reg, pz_reg, px_reg};
            default: ;
        endcase
    end

    // ---- checks ----
    `CSWP_ASSERT_IMP(a_done_in_wait, idone, in_wait, "iterative unit finished outside a wait state")
    `CSWP_ASSERT_NXT(a_out_load, out_load, (m_tvalid_reg && state_reg == S_IDLE), "result not presented after load")

endmodule

/* sv/cswp_iter_unit.sv */
// Shared iterative unit: restoring fractional divide and integer square root.
// Depends on cswp_pkg.
module cswp_iter_unit
    import cswp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  iter_cmd_t   cmd,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic        done,
    output logic [63:0] result
);

    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] aux_reg, aux_next;      // divisor, or the sqrt test bit
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        sqrt_reg, sqrt_next;
    logic        done_reg, done_next;
    logic [63:0] trial;
    logic        ge;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        aux_next  = aux_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        sqrt_next = sqrt_reg;
        done_next = 1'b0;
        trial     = quo_reg + aux_reg;
        ge        = 1'b0;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            sqrt_next = cmd.is_sqrt;
            rem_next  = num;
            quo_next  = '0;
            if (cmd.is_sqrt)
            begin
                aux_next = 64'h4000_0000_0000_0000;
                cnt_next = 6'(SQRT_STEPS);
            end
            else
            begin
                aux_next = den;
                cnt_next = 6'(DIV_STEPS);
            end
        end
        else if (busy_reg)
        begin
            if (sqrt_reg)
            begin
                ge       = rem_reg >= trial;
                rem_next = ge ? rem_reg - trial : rem_reg;
                quo_next = ge ? (quo_reg >> 1) + aux_reg : quo_reg >> 1;
                aux_next = aux_reg >> 2;
            end
            else
            begin
                ge       = rem_reg >= aux_reg;
                rem_next = (ge ? rem_reg - aux_reg : rem_reg) << 1;
                quo_next = {quo_reg[62:0], ge};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            sqrt_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            sqrt_reg <= sqrt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        aux_reg <= aux_next;
    end

    assign done   = done_reg;
    assign result = quo_reg;

endmodule

/* tb/tb_circle_segment_wall_pushout_unit.sv */
// Self-checking testbench for circle_segment_wall_pushout_unit.
// Depends on cswp_pkg and the unit; drives walls/bodies on the stream port
// and checks every result against a fixed-point push-out predictor.
module tb_circle_segment_wall_pushout_unit;
    import cswp_pkg::*;

    typedef struct {
        logic              op;
        logic [2:0]        slot;
        logic signed [31:0] sx, sz, ex, ez;
        logic signed [31:0] px, pz, vx, vz;
    } body_item_t;

    typedef struct {
        logic signed [31:0] px, pz, vx, vz;
        logic [3:0]         hits;
    } pushout_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic              cfg_index;
    logic [30:0]       cfg_data;
    logic              s_tvalid;
    logic              s_tready;
    logic [DIN_W-1:0]  s_tdata;
    logic              s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [DOUT_W-1:0] m_tdata;

    circle_segment_wall_pushout_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Predictor state: its own copy of the wall store and the registers.
    longint     wall_sx [8], wall_sz [8], wall_ex [8], wall_ez [8];
    logic [3:0]  mdl_wall_count;
    logic [30:0] mdl_radius;

    body_item_t pending_items[$];
    pushout_t   expected_pushouts[$];
    int         fail_count;
    bit         no_idle;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ---------------- fixed-point predictor ----------------
    function automatic longint unsigned magn(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic longint shr_tz(longint v, int s);
        longint unsigned m;
        m = magn(v) >> s;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    // trunc(a*b / 2^F)
    function automatic longint qmul(longint a, longint b);
        longint unsigned m;
        m = (magn(a) * magn(b)) >> FRAC_BITS;
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    // trunc(num*2^F / den)
    function automatic longint qdiv(longint num, longint unsigned den);
        longint unsigned m;
        m = (magn(num) << FRAC_BITS) / den;
        return (num < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // clamped projection parameter along the segment, Q format
    function automatic longint seg_param(longint abx, longint abz, longint apx, longint apz);
        longint unsigned m, r, d, q;
        longint len2, dot;
        int s;
        m = magn(abx);
        if (magn(abz) > m) m = magn(abz);
        if (magn(apx) > m) m = magn(apx);
        if (magn(apz) > m) m = magn(apz);
        s = 0;
        while ((m >> s) >= (64'd1 << 30)) s++;
        abx = shr_tz(abx, s); abz = shr_tz(abz, s);
        apx = shr_tz(apx, s); apz = shr_tz(apz, s);
        len2 = abx * abx + abz * abz;
        dot  = apx * abx + apz * abz;
        if (len2 == 0 || dot <= 0) return 0;
        if (dot >= len2) return 64'sd1 << FRAC_BITS;
        r = dot;
        d = len2;
        q = 0;
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= d)
            begin
                r = r - d;
                q = q | 1;
            end
        end
        return longint'(q);
    endfunction

    function automatic pushout_t resolve_body(body_item_t it);
        pushout_t res;
        longint px, pz, vx, vz, ko, abx, abz, t, dx, dz, nx, nz, push, into;
        longint unsigned adx, adz, d_len, ko_u;
        int nwalls, hits;
        px = it.px; pz = it.pz; vx = it.vx; vz = it.vz;
        ko = longint'(mdl_radius) + HALF_WALL;
        ko_u = ko;
        nwalls = (mdl_wall_count > 8) ? 8 : mdl_wall_count;
        hits = 0;
        for (int i = 0; i < nwalls; i++)
        begin
            abx = wall_ex[i] - wall_sx[i];
            abz = wall_ez[i] - wall_sz[i];
            t  = seg_param(abx, abz, px - wall_sx[i], pz - wall_sz[i]);
            dx = px - (wall_sx[i] + qmul(abx, t));
            dz = pz - (wall_sz[i] + qmul(abz, t));
            adx = magn(dx);
            adz = magn(dz);
            if (adx >= ko_u || adz >= ko_u) continue;
            d_len = int_sqrt(adx * adx + adz * adz);
            if (d_len == 0 || d_len >= ko_u) continue;
            nx = qdiv(dx, d_len);
            nz = qdiv(dz, d_len);
            push = ko - longint'(d_len);
            into = shr_tz(vx * nx + vz * nz, FRAC_BITS);
            px = clamp32(px + qmul(nx, push));
            pz = clamp32(pz + qmul(nz, push));
            if (into < 0)
            begin
                vx = clamp32(vx - qmul(nx, into));
                vz = clamp32(vz - qmul(nz, into));
            end
            if (hits < 15) hits++;
        end
        res.px = px[31:0]; res.pz = pz[31:0];
        res.vx = vx[31:0]; res.vz = vz[31:0];
        res.hits = hits[3:0];
        return res;
    endfunction

    // Applies one accepted transfer to the predictor.
    task automatic apply_item(body_item_t it);
        if (it.op == OP_WRITE)
        begin
            wall_sx[it.slot] = it.sx; wall_sz[it.slot] = it.sz;
            wall_ex[it.slot] = it.ex; wall_ez[it.slot] = it.ez;
        end
        else
            expected_pushouts.push_back(resolve_body(it));
    endtask

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ---------------- driver ----------------
    body_item_t drv_item;
    int         drv_gap;

    always @(posedge clk or negedge rst_n)
    begin
        logic next_valid;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            drv_gap  = 0;
        end
        else
        begin
            next_valid = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                apply_item(drv_item);
                next_valid = 1'b0;
                drv_gap = pick_gap();
            end
            if (!next_valid)
            begin
                if (drv_gap > 0)
                    drv_gap--;
                else if (pending_items.size() > 0)
                begin
                    drv_item = pending_items.pop_front();
                    // pad, vel_z, vel_x, pos_z, pos_x, end_z, end_x, start_z, start_x, slot
                    s_tdata <= {5'b0, drv_item.vz, drv_item.vx, drv_item.pz, drv_item.px,
                                drv_item.ez, drv_item.ex, drv_item.sz, drv_item.sx,
                                drv_item.slot};
                    s_tuser <= drv_item.op;
                    next_valid = 1'b1;
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // ---------------- monitor ----------------
    int mon_stall;

    always @(posedge clk or negedge rst_n)
    begin
        pushout_t want;
        pushout_t got;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            mon_stall = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.px = m_tdata[31:0];
                got.pz = m_tdata[63:32];
                got.vx = m_tdata[95:64];
                got.vz = m_tdata[127:96];
                got.hits = m_tdata[131:128];
                if (expected_pushouts.size() == 0)
                begin
                    $display("%0t: unexpected result transfer %h", $time, m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_pushouts.pop_front();
                    if (got.px !== want.px)
                    begin
                        $display("%0t: new_pos_x exp %h got %h", $time, want.px, got.px);
                        fail_count++;
                    end
                    if (got.pz !== want.pz)
                    begin
                        $display("%0t: new_pos_z exp %h got %h", $time, want.pz, got.pz);
                        fail_count++;
                    end
                    if (got.vx !== want.vx)
                    begin
                        $display("%0t: new_vel_x exp %h got %h", $time, want.vx, got.vx);
                        fail_count++;
                    end
                    if (got.vz !== want.vz)
                    begin
                        $display("%0t: new_vel_z exp %h got %h", $time, want.vz, got.vz);
                        fail_count++;
                    end
                    if (got.hits !== want.hits)
                    begin
                        $display("%0t: walls_hit exp %0d got %0d", $time, want.hits, got.hits);
                        fail_count++;
                    end
                end
            end
            if (mon_stall > 0)
            begin
                mon_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                mon_stall = pick_gap();
                m_tready <= (mon_stall == 0);
            end
        end
    end

    // ---------------- stimulus ----------------
    function automatic int near_coord();
        return int'($urandom_range(0, 786432)) - 393216;   // about +-6.0
    endfunction

    function automatic body_item_t wall_item(int slot);
        body_item_t it;
        int r;
        it = '{default: '0};
        it.op = OP_WRITE;
        it.slot = slot[2:0];
        r = $urandom_range(0, 99);
        it.px = $urandom; it.pz = $urandom; it.vx = $urandom; it.vz = $urandom;
        if (r < 10)
        begin
            it.sx = $urandom; it.sz = $urandom; it.ex = $urandom; it.ez = $urandom;
        end
        else
        begin
            it.sx = near_coord(); it.sz = near_coord();
            if (r < 18)
            begin
                // zero-length segment
                it.ex = it.sx; it.ez = it.sz;
            end
            else
            begin
                it.ex = near_coord(); it.ez = near_coord();
            end
        end
        return it;
    endfunction

    function automatic body_item_t body_item();
        body_item_t it;
        int r;
        it.op = OP_RESOLVE;
        it.slot = 3'($urandom);
        it.sx = $urandom; it.sz = $urandom; it.ex = $urandom; it.ez = $urandom;
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            it.px = $urandom; it.pz = $urandom; it.vx = $urandom; it.vz = $urandom;
        end
        else
        begin
            it.px = near_coord(); it.pz = near_coord();
            if (r < 22)
            begin
                it.vx = $urandom; it.vz = $urandom;
            end
            else
            begin
                it.vx = int'($urandom_range(0, 1310720)) - 655360;
                it.vz = int'($urandom_range(0, 1310720)) - 655360;
            end
        end
        return it;
    endfunction

    function automatic body_item_t body_at(int px, int pz, int vx, int vz);
        body_item_t it;
        it = '{default: '0};
        it.op = OP_RESOLVE;
        it.px = px; it.pz = pz; it.vx = vx; it.vz = vz;
        return it;
    endfunction

    task automatic write_reg(logic idx, logic [30:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_WALL_COUNT)
            mdl_wall_count = value[3:0];
        else
            mdl_radius = value;
    endtask

    // Sender holds off until every result is back; then give a trailing
    // write time to finish.
    task automatic drain();
        while (pending_items.size() > 0 || s_tvalid || expected_pushouts.size() > 0)
        begin
            @(posedge clk);
            #1;
        end
        repeat (1000) @(posedge clk);
    endtask

    int          phase_counts [7] = '{15, 8, 1, 8, 4, 9, 8};
    int          phase_radii  [7];
    body_item_t  w;

    initial
    begin
        fail_count = 0;
        no_idle    = 1'b0;
        mdl_wall_count = 4'd0;
        mdl_radius = 31'd65536;
        for (int i = 0; i < 8; i++)
        begin
            wall_sx[i] = 0; wall_sz[i] = 0; wall_ex[i] = 0; wall_ez[i] = 0;
        end
        cfg_we = 1'b0; cfg_index = 1'b0; cfg_data = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: no walls checked yet, so extremes pass straight through.
        pending_items.push_back(body_at(32'h7FFF_FFFF, 32'h8000_0000,
                                        32'h8000_0000, 32'h7FFF_FFFF));
        pending_items.push_back(body_at(0, 0, 0, 0));
        // fill every slot before any wall is read
        w = wall_item(0); w.sx = 65536; w.sz = 65536; w.ex = 65536; w.ez = 65536;
        pending_items.push_back(w);                 // degenerate segment
        w = wall_item(1); w.sx = -262144; w.sz = 0; w.ex = 262144; w.ez = 0;
        pending_items.push_back(w);                 // along X at z = 0
        w = wall_item(2); w.sx = 32'h8000_0000; w.sz = 32'h8000_0000;
        w.ex = 32'h7FFF_FFFF; w.ez = 32'h7FFF_FFFF;
        pending_items.push_back(w);                 // full-range wall, needs scaling
        for (int s = 3; s < 8; s++) pending_items.push_back(wall_item(s));
        drain();

        write_reg(CFG_WALL_COUNT, 31'd15);          // above the wall limit
        pending_items.push_back(body_at(65536, 0, 0, 0));             // on the segment
        pending_items.push_back(body_at(0, 32768, 0, -65536));        // moving into wall
        pending_items.push_back(body_at(0, -32768, 0, 65536));
        pending_items.push_back(body_at(65536, 65536 + 1000, 131072, 0));
        pending_items.push_back(body_at(32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                        32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_items.push_back(body_at(32'h8000_0000, 32'h8000_0000,
                                        32'h8000_0000, 32'h8000_0000));
        pending_items.push_back(body_at(-300000, 1000, 32'h8000_0000, 32'h8000_0000));
        drain();

        phase_radii = '{65536, 0, 32'h7FFF_FFFF, 131072, 40000, 19660, 98304};
        phase_radii[4] = $urandom_range(1000, 200000);
        for (int p = 0; p < 7; p++)
        begin
            write_reg(CFG_WALL_COUNT, 31'(phase_counts[p]));
            write_reg(CFG_BODY_RADIUS, 31'(phase_radii[p]));
            no_idle = (p == 3);
            for (int k = 0; k < 90; k++)
            begin
                if ($urandom_range(0, 99) < 22)
                    pending_items.push_back(wall_item($urandom_range(0, 7)));
                else
                    pending_items.push_back(body_item());
            end
            drain();
        end

        if (fail_count == 0)
            $display("circle_segment_wall_pushout_unit test passed");
        else
            $display("circle_segment_wall_pushout_unit test failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #200_000_000;
        $display("circle_segment_wall_pushout_unit test failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/cswp_pkg.sv
sv/cswp_iter_unit.sv
sv/circle_segment_wall_pushout_unit.sv
tb/tb_circle_segment_wall_pushout_unit.sv
